/* rtl/core/uoc_pkg.sv */
`default_nettype none

package uoc_pkg;

   localparam int MAX_CHUNK   = 256;
   localparam int RING_AW     = $clog2(MAX_CHUNK);
   localparam int OFF_BITS    = 32;
   localparam int CNT_W       = 32;
   localparam int OUT_W       = 32;
   localparam int SIZE_W      = 9;
   localparam int OVL_W       = 8;
   localparam int CSR_IDX_W   = 8;
   localparam int CSR_DATA_W  = 9;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] LEAD_MASK = 8'hC0;
   localparam logic [7:0] CONT_TAG  = 8'h80;

   localparam logic [OFF_BITS-1:0] OFF_MAX = {OFF_BITS{1'b1}};

   localparam logic [SIZE_W-1:0] CHUNK_SIZE_RST = SIZE_W'(256);
   localparam logic [OVL_W-1:0]  OVERLAP_RST    = '0;
   localparam logic [SIZE_W-1:0] SIZE_MAX       = SIZE_W'(MAX_CHUNK);

   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_SIZE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_OVERLAP    = CSR_IDX_W'(1);

   typedef logic [OFF_BITS-1:0] offset_type;
   typedef logic [RING_AW-1:0]  ring_addr_type;

   typedef struct packed {
      logic          we;
      ring_addr_type waddr;
      offset_type    wdata;
      ring_addr_type raddr_emit;
      ring_addr_type raddr_final;
   } ring_req_type;

   typedef struct packed {
      logic       valid;
      logic       emit;
      logic       fin;
      logic       fwd;
      offset_type pos;
      offset_type next_pos;
   } item_ctl_type;

   typedef struct packed {
      logic [OUT_W-1:0] start;
      logic [OUT_W-1:0] length;
      logic             fin;
      logic             eor;
   } rsp_entry_type;

endpackage

`default_nettype wire

/* rtl/core/uoc_ring.sv */
`default_nettype none

module uoc_ring import uoc_pkg::*; (
   input  wire logic         clock,
   input  wire ring_req_type ring_req,
   output offset_type        rd_emit_ff,
   output offset_type        rd_final_ff
);

   offset_type mem [MAX_CHUNK];

   always_ff @(posedge clock) begin
      if (ring_req.we) begin
         mem[ring_req.waddr] <= ring_req.wdata;
      end
      rd_emit_ff  <= mem[ring_req.raddr_emit];
      rd_final_ff <= mem[ring_req.raddr_final];
   end

endmodule

`default_nettype wire

/* rtl/core/uoc_ctrl.sv */
`default_nettype none

module uoc_ctrl import uoc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_text_byte,
   input  wire logic                  req_end_of_text,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [QUEUE_CW-1:0]   queue_count,
   output ring_req_type               ring_req,
   output item_ctl_type               item_ff
);

   logic [SIZE_W-1:0] chunk_size_ff, chunk_size_in;
   logic [OVL_W-1:0]  overlap_ff, overlap_in;
   offset_type        pos_ff, pos_in;
   logic [CNT_W-1:0]  cps_ff, cps_in;
   logic [CNT_W-1:0]  psi_ff, psi_in;
   logic              any_ff, any_in;
   item_ctl_type      item_in;

   logic [SIZE_W-1:0] size;
   logic [SIZE_W-1:0] ovl;
   logic [SIZE_W-1:0] stride;
   logic [CNT_W-1:0]  cp_gap;
   logic [CNT_W-1:0]  psi_mid;
   logic              accept;
   logic              lead;
   logic              emit;
   logic              any_mid;
   offset_type        next_pos;
   logic [1:0]        item_results;

   assign csr_ready = 1'b1;

   always_comb begin
      chunk_size_in = chunk_size_ff;
      overlap_in    = overlap_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_CHUNK_SIZE) begin
            chunk_size_in = csr_wdata;
         end else if (csr_index == CSR_OVERLAP) begin
            overlap_in = csr_wdata[OVL_W-1:0];
         end
      end
   end

   always_comb begin
      if (chunk_size_ff == '0) begin
         size = SIZE_W'(1);
      end else if (chunk_size_ff > SIZE_MAX) begin
         size = SIZE_MAX;
      end else begin
         size = chunk_size_ff;
      end
      ovl    = (SIZE_W'(overlap_ff) < size - SIZE_W'(1)) ? SIZE_W'(overlap_ff)
                                                         : size - SIZE_W'(1);
      stride = size - ovl;
   end

   assign item_results = 2'(item_ff.valid & item_ff.emit) + 2'(item_ff.valid & item_ff.fin);
   assign req_ready    = (queue_count + QUEUE_CW'(item_results)) <= QUEUE_CW'(2);
   assign accept       = req_valid && req_ready;

   always_comb begin
      lead     = (req_text_byte & LEAD_MASK) != CONT_TAG;
      cp_gap   = cps_ff - psi_ff;
      emit     = lead && any_ff && (cp_gap >= CNT_W'(size));
      psi_mid  = emit ? psi_ff + CNT_W'(stride) : psi_ff;
      any_mid  = any_ff || lead;
      next_pos = (pos_ff == OFF_MAX) ? pos_ff : pos_ff + OFF_BITS'(1);

      ring_req.we          = accept && lead;
      ring_req.waddr       = cps_ff[RING_AW-1:0];
      ring_req.wdata       = pos_ff;
      ring_req.raddr_emit  = psi_ff[RING_AW-1:0];
      ring_req.raddr_final = psi_mid[RING_AW-1:0];

      item_in.valid    = accept;
      item_in.emit     = emit;
      item_in.fin      = req_end_of_text && any_mid;
      item_in.fwd      = lead && (psi_mid[RING_AW-1:0] == cps_ff[RING_AW-1:0]);
      item_in.pos      = pos_ff;
      item_in.next_pos = next_pos;

      pos_in = pos_ff;
      cps_in = cps_ff;
      psi_in = psi_ff;
      any_in = any_ff;
      if (accept) begin
         if (req_end_of_text) begin
            pos_in = '0;
            cps_in = '0;
            psi_in = '0;
            any_in = 1'b0;
         end else begin
            pos_in = next_pos;
            cps_in = lead ? cps_ff + CNT_W'(1) : cps_ff;
            psi_in = psi_mid;
            any_in = any_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff <= CHUNK_SIZE_RST;
         overlap_ff    <= OVERLAP_RST;
         pos_ff        <= '0;
         cps_ff        <= '0;
         psi_ff        <= '0;
         any_ff        <= 1'b0;
         item_ff.valid <= 1'b0;
      end else begin
         chunk_size_ff <= chunk_size_in;
         overlap_ff    <= overlap_in;
         pos_ff        <= pos_in;
         cps_ff        <= cps_in;
         psi_ff        <= psi_in;
         any_ff        <= any_in;
         item_ff.valid <= item_in.valid;
      end
      item_ff.emit     <= item_in.emit;
      item_ff.fin      <= item_in.fin;
      item_ff.fwd      <= item_in.fwd;
      item_ff.pos      <= item_in.pos;
      item_ff.next_pos <= item_in.next_pos;
   end

endmodule

`default_nettype wire

/* rtl/core/uoc_queue.sv */
`default_nettype none

module uoc_queue import uoc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire item_ctl_type       item,
   input  wire offset_type         rd_emit,
   input  wire offset_type         rd_final,
   output logic [QUEUE_CW-1:0]     count_ff,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [OUT_W-1:0]        rsp_chunk_start_byte,
   output logic [OUT_W-1:0]        rsp_chunk_length_bytes,
   output logic                    rsp_final_chunk,
   output logic                    rsp_end_of_run
);

   rsp_entry_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]       wptr_ff, wptr_in;
   logic [QUEUE_AW-1:0]       rptr_ff, rptr_in;
   logic [QUEUE_CW-1:0]       count_in;

   rsp_entry_type             emit_entry;
   rsp_entry_type             final_entry;
   rsp_entry_type             first_entry;
   offset_type                final_start;
   logic [1:0]                push_n;
   logic                      pop;

   always_comb begin
      final_start = item.fwd ? item.pos : rd_final;

      emit_entry.start  = OUT_W'(rd_emit);
      emit_entry.length = OUT_W'(item.pos - rd_emit);
      emit_entry.fin    = 1'b0;
      emit_entry.eor    = !item.fin;

      final_entry.start  = OUT_W'(final_start);
      final_entry.length = OUT_W'(item.next_pos - final_start);
      final_entry.fin    = 1'b1;
      final_entry.eor    = 1'b1;

      first_entry = item.emit ? emit_entry : final_entry;
      push_n      = item.valid ? 2'(item.emit) + 2'(item.fin) : 2'd0;

      pop      = rsp_valid && rsp_ready;
      wptr_in  = wptr_ff + QUEUE_AW'(push_n);
      rptr_in  = pop ? rptr_ff + QUEUE_AW'(1) : rptr_ff;
      count_in = count_ff + QUEUE_CW'(push_n) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push_n != 2'd0) begin
         entry_ff[wptr_ff] <= first_entry;
      end
      if (push_n == 2'd2) begin
         entry_ff[wptr_ff + QUEUE_AW'(1)] <= final_entry;
      end
   end

   assign rsp_valid              = count_ff != '0;
   assign rsp_chunk_start_byte   = entry_ff[rptr_ff].start;
   assign rsp_chunk_length_bytes = entry_ff[rptr_ff].length;
   assign rsp_final_chunk        = entry_ff[rptr_ff].fin;
   assign rsp_end_of_run         = entry_ff[rptr_ff].eor;

endmodule

`default_nettype wire

/* rtl/core/utf8_overlapping_chunker.sv */
// Splits a UTF-8 byte stream into overlapping windows of whole codepoints.
// Bytes arrive on the req_ channel, one per transfer, with req_end_of_text
// marking the last byte of a text. Each window comes out on the rsp_ channel
// as a byte start and byte length; a byte may cause zero, one or two
// transfers, and rsp_end_of_run marks the last one it causes.
// The csr_ channel writes chunk_size (index 0) and overlap (index 1); it is
// always ready and should be written only while no text is in progress.
// A result is offered once it stands in the result queue: the start-offset
// ring is read and the byte's control is registered at the accepting edge,
// and the chunk is formed from them as it is written into the result queue.
// One byte is taken per cycle while the result queue has room; a byte that
// causes two results takes two output transfers, as the result channel
// moves one transfer per cycle while rsp_ready is high. The ring holds 256
// entries with one write and two read ports; it needs no clearing pass.
// When the receiver stalls, results collect in a four-entry queue and
// req_ready drops once the queue, counting the results still being formed,
// cannot take two more.
// Reset clears the text state and queue and sets chunk_size to 256 and
// overlap to 0. After a byte with req_end_of_text the block starts over.
`default_nettype none

module utf8_overlapping_chunker import uoc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_text_byte,
   input  wire logic                  req_end_of_text,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [OUT_W-1:0]           rsp_chunk_start_byte,
   output logic [OUT_W-1:0]           rsp_chunk_length_bytes,
   output logic                       rsp_final_chunk,
   output logic                       rsp_end_of_run,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   ring_req_type          ring_req;
   item_ctl_type          item;
   offset_type            rd_emit;
   offset_type            rd_final;
   logic [QUEUE_CW-1:0]   queue_count;

   uoc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_text_byte   (req_text_byte),
      .req_end_of_text (req_end_of_text),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .queue_count     (queue_count),
      .ring_req        (ring_req),
      .item_ff         (item)
   );

   uoc_ring u_ring (
      .clock       (clock),
      .ring_req    (ring_req),
      .rd_emit_ff  (rd_emit),
      .rd_final_ff (rd_final)
   );

   uoc_queue u_queue (
      .clock                  (clock),
      .reset                  (reset),
      .item                   (item),
      .rd_emit                (rd_emit),
      .rd_final               (rd_final),
      .count_ff               (queue_count),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_chunk_start_byte   (rsp_chunk_start_byte),
      .rsp_chunk_length_bytes (rsp_chunk_length_bytes),
      .rsp_final_chunk        (rsp_final_chunk),
      .rsp_end_of_run         (rsp_end_of_run)
   );

endmodule

`default_nettype wire

/* test/utf8_overlapping_chunker_test.sv */
module utf8_overlapping_chunker_test import uoc_pkg::*;;

   localparam int HALF_PERIOD = 6;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int TARGET_BYTES = 1700;

   // Tracks the open window of the current text and queues the chunks it owes.
   class window_tracker;
      logic [SIZE_W-1:0] size_reg;
      logic [OVL_W-1:0] overlap_reg;
      offset_type next_offset;
      logic [CNT_W-1:0] cp_count;
      logic [CNT_W-1:0] window_first;
      offset_type start_ring [MAX_CHUNK];
      ring_addr_type ring_wr;
      bit text_has_start;
      rsp_entry_type due_chunks[$];
      int errors;
      int chunks;
      int finals;

      function new();
         size_reg = CHUNK_SIZE_RST;
         overlap_reg = OVERLAP_RST;
         errors = 0;
         chunks = 0;
         finals = 0;
         restart_text();
      endfunction

      function void restart_text();
         next_offset = '0;
         cp_count = '0;
         window_first = '0;
         ring_wr = '0;
         text_has_start = 1'b0;
         foreach (start_ring[i]) start_ring[i] = '0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_CHUNK_SIZE) begin
            size_reg = data[SIZE_W-1:0];
         end else if (idx == CSR_OVERLAP) begin
            overlap_reg = data[OVL_W-1:0];
         end
      endfunction

      function int outstanding();
         return due_chunks.size();
      endfunction

      function void take_byte(logic [7:0] value, logic is_last);
         logic [CNT_W-1:0] span;
         logic [CNT_W-1:0] clip;
         logic [CNT_W-1:0] cp_gap;
         offset_type here;
         offset_type origin;
         ring_addr_type slot;
         rsp_entry_type made [2];
         int n;
         int k;
         span = (size_reg == 0) ? 1 : size_reg;
         if (span > MAX_CHUNK) span = MAX_CHUNK;
         clip = (overlap_reg < span - 1) ? overlap_reg : span - 1;
         here = next_offset;
         n = 0;
         if ((value & LEAD_MASK) != CONT_TAG) begin
            cp_gap = cp_count - window_first;
            if (text_has_start && cp_gap >= span) begin
               slot = ring_wr - cp_gap[RING_AW-1:0];
               origin = start_ring[slot];
               made[n] = '{start: origin, length: here - origin, fin: 1'b0, eor: 1'b0};
               n++;
               window_first += span - clip;
            end
            start_ring[ring_wr] = here;
            ring_wr++;
            cp_count++;
            text_has_start = 1'b1;
         end
         next_offset = (here == OFF_MAX) ? here : here + 1;
         if (is_last) begin
            if (text_has_start) begin
               cp_gap = cp_count - 1 - window_first;
               slot = ring_wr - RING_AW'(1) - cp_gap[RING_AW-1:0];
               origin = start_ring[slot];
               made[n] = '{start: origin, length: next_offset - origin, fin: 1'b1, eor: 1'b0};
               n++;
            end
            restart_text();
         end
         for (k = 0; k < n; k++) begin
            if (k == n - 1) made[k].eor = 1'b1;
            due_chunks.insert(due_chunks.size(), made[k]);
         end
      endfunction

      function void match_chunk(logic [OUT_W-1:0] start, logic [OUT_W-1:0] length,
                                logic fin, logic eor);
         rsp_entry_type want;
         if (due_chunks.size() == 0) begin
            errors++;
            $display("%0t: unexpected chunk, start %0d length %0d final %0b end %0b",
                     $time, start, length, fin, eor);
            return;
         end
         want = due_chunks.pop_front();
         chunks++;
         if (want.fin) finals++;
         if (want.start !== start) begin
            errors++;
            $display("%0t: chunk start expected %0d, got %0d", $time, want.start, start);
         end
         if (want.length !== length) begin
            errors++;
            $display("%0t: chunk length expected %0d, got %0d", $time, want.length, length);
         end
         if (want.fin !== fin) begin
            errors++;
            $display("%0t: final flag expected %0b, got %0b", $time, want.fin, fin);
         end
         if (want.eor !== eor) begin
            errors++;
            $display("%0t: end of run expected %0b, got %0b", $time, want.eor, eor);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_text_byte = '0;
   logic req_end_of_text = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [OUT_W-1:0] rsp_chunk_start_byte;
   logic [OUT_W-1:0] rsp_chunk_length_bytes;
   logic rsp_final_chunk;
   logic rsp_end_of_run;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   window_tracker tracker = new();
   int cycle_count = 0;
   int byte_count = 0;
   int text_count = 0;
   int csr_writes = 0;
   bit send_calm = 1'b0;
   bit recv_calm = 1'b0;

   utf8_overlapping_chunker uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_text_byte(req_text_byte),
      .req_end_of_text(req_end_of_text),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_chunk_start_byte(rsp_chunk_start_byte),
      .rsp_chunk_length_bytes(rsp_chunk_length_bytes),
      .rsp_final_chunk(rsp_final_chunk),
      .rsp_end_of_run(rsp_end_of_run),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("utf8_overlapping_chunker_test: errors");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) tracker.write_reg(csr_index, csr_wdata);
         if (req_valid && req_ready) tracker.take_byte(req_text_byte, req_end_of_text);
         if (rsp_valid && rsp_ready) begin
            tracker.match_chunk(rsp_chunk_start_byte, rsp_chunk_length_bytes,
                                rsp_final_chunk, rsp_end_of_run);
         end
      end
   end

   initial begin
      int gap;
      forever begin
         gap = recv_calm ? 0 : $urandom_range(0, 12);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task send_byte(input logic [7:0] value, input logic is_last);
      int gap;
      gap = send_calm ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_text_byte <= value;
      req_end_of_text <= is_last;
      do @(posedge clock); while (!req_ready);
      byte_count++;
      if (is_last) text_count++;
   endtask

   task settle(input int extra);
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      settle(SETTLE_CYCLES);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   task setup(input logic [CSR_DATA_W-1:0] size, input logic [OVL_W-1:0] ovl);
      write_reg(CSR_CHUNK_SIZE, size);
      write_reg(CSR_OVERLAP, {1'($urandom), ovl});
      if ($urandom_range(0, 2) == 0) begin
         write_reg(CSR_IDX_W'($urandom_range(CSR_OVERLAP + 1, {CSR_IDX_W{1'b1}})),
                   CSR_DATA_W'($urandom));
      end
      send_calm = ($urandom_range(0, 3) == 0);
      recv_calm = ($urandom_range(0, 3) == 0);
   endtask

   task send_text(input int n_cp, input bit ascii, input bit pause_mid);
      logic [7:0] text_q[$];
      logic [7:0] lead;
      int len;
      int i;
      int k;
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 4)) text_q.insert(text_q.size(), {2'b10, 6'($urandom)});
      end else begin
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) text_q.insert(text_q.size(), {2'b10, 6'($urandom)});
         end
         for (i = 0; i < n_cp; i++) begin
            len = (ascii && $urandom_range(0, 9) < 8) ? 1 : $urandom_range(1, 4);
            case (len)
               1: lead = {1'b0, 7'($urandom)};
               2: lead = {3'b110, 5'($urandom)};
               3: lead = {4'b1110, 4'($urandom)};
               default: lead = {5'b11110, 3'($urandom)};
            endcase
            if ($urandom_range(0, 11) == 0) lead = 8'($urandom);
            text_q.insert(text_q.size(), lead);
            for (k = 1; k < len; k++) begin
               text_q.insert(text_q.size(), ($urandom_range(0, 15) == 0) ? 8'($urandom)
                                                                         : {2'b10, 6'($urandom)});
            end
         end
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) text_q.insert(text_q.size(), {2'b10, 6'($urandom)});
         end
      end
      for (k = 0; k < text_q.size(); k++) begin
         if (pause_mid && k == text_q.size() / 2) settle(0);
         send_byte(text_q[k], k == text_q.size() - 1);
      end
   endtask

   task run_texts(input int count, input int max_cp, input bit ascii);
      repeat (count) send_text($urandom_range(1, max_cp), ascii, 1'b0);
   endtask

   initial begin
      int size_pick;
      int ovl_pick;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_byte(8'h80, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'hBF, 1'b1);
      send_byte(8'h7F, 1'b1);

      setup(9'd1, 8'd0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b1);

      setup(9'd3, 8'd2);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b0);
      send_byte(8'hC0, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'h98, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h80, 1'b1);

      setup(9'd0, 8'd0);
      run_texts(4, 20, 1'b0);
      setup(9'd1, 8'd255);
      run_texts(4, 20, 1'b0);
      setup(9'd2, 8'd1);
      send_text(40, 1'b0, 1'b1);
      run_texts(4, 24, 1'b0);
      setup(9'd256, 8'd255);
      send_text(280, 1'b1, 1'b0);
      setup(9'h1FF, 8'd0);
      send_text(270, 1'b1, 1'b0);
      setup(9'd257, 8'd128);
      send_text(40, 1'b1, 1'b0);

      while (byte_count < TARGET_BYTES) begin
         size_pick = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 8);
         ovl_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, size_pick);
         setup(CSR_DATA_W'(size_pick), OVL_W'(ovl_pick));
         run_texts($urandom_range(3, 6), 3 * size_pick + 4, 1'($urandom));
      end

      settle(SETTLE_CYCLES);
      $display("Sent %0d bytes in %0d texts across %0d register writes.",
               byte_count, text_count, csr_writes);
      $display("Checked %0d chunks, %0d of them final.", tracker.chunks, tracker.finals);
      if (tracker.errors == 0) begin
         $display("utf8_overlapping_chunker_test: clean");
      end else begin
         $display("utf8_overlapping_chunker_test: errors");
      end
      $finish;
   end

endmodule
